// ----- src/cts_pkg.sv -----
`default_nettype none
package cts_pkg;

	// line counter width
	localparam int LINE_BITS = 16;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// result kinds
	localparam logic [1:0] KIND_LEX = 2'd0;
	localparam logic [1:0] KIND_TOK = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// token types
	localparam logic [4:0] TOK_NONE   = 5'd0;
	localparam logic [4:0] TOK_ID     = 5'd1;
	localparam logic [4:0] TOK_INT    = 5'd2;
	localparam logic [4:0] TOK_CHAR   = 5'd3;
	localparam logic [4:0] TOK_STR    = 5'd4;
	localparam logic [4:0] TOK_PLUS   = 5'd5;
	localparam logic [4:0] TOK_MINUS  = 5'd6;
	localparam logic [4:0] TOK_STAR   = 5'd7;
	localparam logic [4:0] TOK_SLASH  = 5'd8;
	localparam logic [4:0] TOK_ASSIGN = 5'd9;
	localparam logic [4:0] TOK_EQ     = 5'd10;
	localparam logic [4:0] TOK_NE     = 5'd11;
	localparam logic [4:0] TOK_LT     = 5'd12;
	localparam logic [4:0] TOK_LE     = 5'd13;
	localparam logic [4:0] TOK_GT     = 5'd14;
	localparam logic [4:0] TOK_GE     = 5'd15;
	localparam logic [4:0] TOK_LAND   = 5'd16;
	localparam logic [4:0] TOK_LOR    = 5'd17;
	localparam logic [4:0] TOK_NOT    = 5'd18;
	localparam logic [4:0] TOK_LPAREN = 5'd19;
	localparam logic [4:0] TOK_RPAREN = 5'd20;
	localparam logic [4:0] TOK_LBRACK = 5'd21;
	localparam logic [4:0] TOK_RBRACK = 5'd22;
	localparam logic [4:0] TOK_LBRACE = 5'd23;
	localparam logic [4:0] TOK_RBRACE = 5'd24;
	localparam logic [4:0] TOK_COMMA  = 5'd25;
	localparam logic [4:0] TOK_SEMI   = 5'd26;
	localparam logic [4:0] TOK_END    = 5'd27;

	// error codes
	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_BAD_CHAR   = 4'd0;
	localparam logic [3:0] ERR_LONE_AMP   = 4'd1;
	localparam logic [3:0] ERR_LONE_BAR   = 4'd2;
	localparam logic [3:0] ERR_INT_ALPHA  = 4'd3;
	localparam logic [3:0] ERR_CHC_FORMAT = 4'd4;
	localparam logic [3:0] ERR_CHC_UNPRT  = 4'd5;
	localparam logic [3:0] ERR_STR_OPEN   = 4'd6;
	localparam logic [3:0] ERR_STR_UNPRT  = 4'd7;
	localparam logic [3:0] ERR_COM_OPEN   = 4'd8;

	// one result item
	typedef struct packed {
		logic [1:0]           kind;
		logic [4:0]           token_type;
		logic [7:0]           char_value;
		logic [3:0]           error_code;
		logic [LINE_BITS-1:0] line_number;
		logic                 last_of_run;
	} res_t;

	// results produced by one accepted byte
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

// ----- src/cts_in_if.sv -----
`default_nettype none
interface cts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// ----- src/cts_out_if.sv -----
`default_nettype none
interface cts_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    result_kind;
	logic [4:0]                    token_type;
	logic [7:0]                    char_value;
	logic [3:0]                    error_code;
	logic [cts_pkg::LINE_BITS-1:0] line_number;
	logic                          last_of_run;

	modport source (output valid, output result_kind, output token_type, output char_value,
		output error_code, output line_number, output last_of_run, input ready);
	modport sink (input valid, input result_kind, input token_type, input char_value,
		input error_code, input line_number, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/cts_scan.sv -----
`default_nettype none
module cts_scan (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    char_code,
	output cts_pkg::push_t     push
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ID, ST_INT, ST_CH_OPEN, ST_CH_ESC, ST_CH_CLOSE, ST_STR,
		ST_SLASH, ST_LCOM, ST_BCOM, ST_BSTAR, ST_EQ, ST_BANG, ST_LT, ST_GT,
		ST_AMP, ST_BAR
	} state_t;

	localparam logic [cts_pkg::LINE_BITS-1:0] LINE_MAX = '1;
	localparam logic [cts_pkg::LINE_BITS-1:0] LINE_ONE = cts_pkg::LINE_BITS'(1);

	state_t                        state_q, state_n;
	logic [cts_pkg::LINE_BITS-1:0] line_q, line_n;

	// first part: result of the current state; second part: rescan from idle
	logic       a_v, b_v, rescan, bump, dec;
	logic [1:0] a_kind, b_kind;
	logic [4:0] a_tok, b_tok;
	logic [7:0] a_ch, b_ch;
	logic [3:0] a_err, b_err;
	logic       c_alpha, c_digit, c_space, c_print;
	logic [7:0] c;

	assign c       = char_code;
	assign c_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	assign c_digit = c >= 8'h30 && c <= 8'h39;
	assign c_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	assign c_print = c >= 8'h20 && c <= 8'h7E;

	// next state and result decode
	always_comb begin
		a_v     = 1'b0;
		a_kind  = cts_pkg::KIND_LEX;
		a_tok   = cts_pkg::TOK_NONE;
		a_ch    = 8'd0;
		a_err   = cts_pkg::ERR_NONE;
		b_v     = 1'b0;
		b_kind  = cts_pkg::KIND_LEX;
		b_tok   = cts_pkg::TOK_NONE;
		b_ch    = 8'd0;
		b_err   = cts_pkg::ERR_NONE;
		rescan  = 1'b0;
		bump    = 1'b0;
		dec     = 1'b0;
		state_n = state_q;

		case (state_q)
			ST_ID: begin
				a_v = 1'b1;
				if (c_alpha || c_digit || c == 8'h5F) begin
					a_ch = c;
				end else begin
					a_kind = cts_pkg::KIND_TOK;
					a_tok  = cts_pkg::TOK_ID;
					rescan = 1'b1;
				end
			end
			ST_INT: begin
				a_v = 1'b1;
				if (c_digit) begin
					a_ch = c;
				end else if (c_alpha) begin
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_INT_ALPHA;
					state_n = ST_IDLE;
				end else begin
					a_kind = cts_pkg::KIND_TOK;
					a_tok  = cts_pkg::TOK_INT;
					rescan = 1'b1;
				end
			end
			ST_CH_OPEN: begin
				if (c == 8'h5C) begin
					state_n = ST_CH_ESC;
				end else if (c == 8'h27) begin
					a_v     = 1'b1;
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_CHC_FORMAT;
					state_n = ST_IDLE;
				end else if (c_print) begin
					a_v     = 1'b1;
					a_ch    = c;
					state_n = ST_CH_CLOSE;
				end else begin
					a_v     = 1'b1;
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_CHC_UNPRT;
					state_n = ST_IDLE;
				end
			end
			ST_CH_ESC: begin
				a_v = 1'b1;
				if (c == 8'h6E) begin
					a_ch    = 8'h0A;
					state_n = ST_CH_CLOSE;
				end else if (c == 8'h30) begin
					a_ch    = 8'h00;
					state_n = ST_CH_CLOSE;
				end else begin
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_CHC_FORMAT;
					state_n = ST_IDLE;
				end
			end
			ST_CH_CLOSE: begin
				a_v     = 1'b1;
				state_n = ST_IDLE;
				if (c == 8'h27) begin
					a_kind = cts_pkg::KIND_TOK;
					a_tok  = cts_pkg::TOK_CHAR;
				end else begin
					a_kind = cts_pkg::KIND_ERR;
					a_err  = cts_pkg::ERR_CHC_FORMAT;
				end
			end
			ST_STR: begin
				a_v = 1'b1;
				if (c == 8'h22) begin
					a_kind  = cts_pkg::KIND_TOK;
					a_tok   = cts_pkg::TOK_STR;
					state_n = ST_IDLE;
				end else if (c == 8'h00) begin
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_STR_OPEN;
					state_n = ST_IDLE;
				end else if (c_print) begin
					a_ch = c;
				end else begin
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_STR_UNPRT;
					state_n = ST_IDLE;
				end
			end
			ST_SLASH: begin
				if (c == 8'h2F) begin
					state_n = ST_LCOM;
				end else if (c == 8'h2A) begin
					state_n = ST_BCOM;
				end else begin
					a_v    = 1'b1;
					a_kind = cts_pkg::KIND_TOK;
					a_tok  = cts_pkg::TOK_SLASH;
					rescan = 1'b1;
				end
			end
			ST_LCOM: begin
				if (c == 8'h0A) begin
					bump    = 1'b1;
					state_n = ST_IDLE;
				end else if (c == 8'h00) begin
					rescan = 1'b1;
				end
			end
			ST_BCOM, ST_BSTAR: begin
				if (state_q == ST_BSTAR && c == 8'h2F) begin
					state_n = ST_IDLE;
				end else if (c == 8'h00) begin
					a_v     = 1'b1;
					a_kind  = cts_pkg::KIND_ERR;
					a_err   = cts_pkg::ERR_COM_OPEN;
					state_n = ST_IDLE;
				end else if (c == 8'h2A) begin
					state_n = ST_BSTAR;
				end else begin
					bump    = c == 8'h0A;
					state_n = ST_BCOM;
				end
			end
			ST_EQ, ST_BANG, ST_LT, ST_GT: begin
				a_v    = 1'b1;
				a_kind = cts_pkg::KIND_TOK;
				if (c == 8'h3D) begin
					state_n = ST_IDLE;
					case (state_q)
						ST_EQ:   a_tok = cts_pkg::TOK_EQ;
						ST_BANG: a_tok = cts_pkg::TOK_NE;
						ST_LT:   a_tok = cts_pkg::TOK_LE;
						default: a_tok = cts_pkg::TOK_GE;
					endcase
				end else begin
					rescan = 1'b1;
					case (state_q)
						ST_EQ:   a_tok = cts_pkg::TOK_ASSIGN;
						ST_BANG: a_tok = cts_pkg::TOK_NOT;
						ST_LT:   a_tok = cts_pkg::TOK_LT;
						default: a_tok = cts_pkg::TOK_GT;
					endcase
				end
			end
			ST_AMP: begin
				a_v     = 1'b1;
				state_n = ST_IDLE;
				if (c == 8'h26) begin
					a_kind = cts_pkg::KIND_TOK;
					a_tok  = cts_pkg::TOK_LAND;
				end else begin
					a_kind = cts_pkg::KIND_ERR;
					a_err  = cts_pkg::ERR_LONE_AMP;
				end
			end
			ST_BAR: begin
				a_v     = 1'b1;
				state_n = ST_IDLE;
				if (c == 8'h7C) begin
					a_kind = cts_pkg::KIND_TOK;
					a_tok  = cts_pkg::TOK_LOR;
				end else begin
					a_kind = cts_pkg::KIND_ERR;
					a_err  = cts_pkg::ERR_LONE_BAR;
				end
			end
			default: rescan = 1'b1;
		endcase

		// scan the byte from idle
		if (rescan) begin
			state_n = ST_IDLE;
			if (c_space) begin
				bump = c == 8'h0A;
			end else if (c_alpha || c_digit) begin
				b_v     = 1'b1;
				b_ch    = c;
				state_n = c_alpha ? ST_ID : ST_INT;
			end else begin
				b_v    = 1'b1;
				b_kind = cts_pkg::KIND_TOK;
				case (c)
					8'h27: begin b_v = 1'b0; state_n = ST_CH_OPEN; end
					8'h22: begin b_v = 1'b0; state_n = ST_STR; end
					8'h2F: begin b_v = 1'b0; state_n = ST_SLASH; end
					8'h3D: begin b_v = 1'b0; state_n = ST_EQ; end
					8'h26: begin b_v = 1'b0; state_n = ST_AMP; end
					8'h7C: begin b_v = 1'b0; state_n = ST_BAR; end
					8'h21: begin b_v = 1'b0; state_n = ST_BANG; end
					8'h3C: begin b_v = 1'b0; state_n = ST_LT; end
					8'h3E: begin b_v = 1'b0; state_n = ST_GT; end
					8'h2B: b_tok = cts_pkg::TOK_PLUS;
					8'h2D: b_tok = cts_pkg::TOK_MINUS;
					8'h2A: b_tok = cts_pkg::TOK_STAR;
					8'h28: b_tok = cts_pkg::TOK_LPAREN;
					8'h29: b_tok = cts_pkg::TOK_RPAREN;
					8'h5B: b_tok = cts_pkg::TOK_LBRACK;
					8'h5D: b_tok = cts_pkg::TOK_RBRACK;
					8'h7B: b_tok = cts_pkg::TOK_LBRACE;
					8'h7D: b_tok = cts_pkg::TOK_RBRACE;
					8'h2C: b_tok = cts_pkg::TOK_COMMA;
					8'h3B: b_tok = cts_pkg::TOK_SEMI;
					8'h00: begin
						dec   = 1'b1;
						b_tok = cts_pkg::TOK_END;
					end
					default: begin
						b_kind = cts_pkg::KIND_ERR;
						b_err  = cts_pkg::ERR_BAD_CHAR;
					end
				endcase
			end
		end
	end

	// line counter: saturating bump, end of input steps back but not below one
	always_comb begin
		line_n = line_q;
		if (bump && line_q != LINE_MAX) begin
			line_n = line_q + LINE_ONE;
		end else if (dec && line_q > LINE_ONE) begin
			line_n = line_q - LINE_ONE;
		end
	end

	// pack results: state part goes first, its results carry the old line
	always_comb begin
		push.count = {1'b0, a_v} + {1'b0, b_v};
		push.r0 = '{kind: a_kind, token_type: a_tok, char_value: a_ch, error_code: a_err,
			line_number: line_q, last_of_run: !b_v};
		push.r1 = '{kind: b_kind, token_type: b_tok, char_value: b_ch, error_code: b_err,
			line_number: line_n, last_of_run: 1'b1};
		if (!a_v) begin
			push.r0 = push.r1;
		end
		if (!accept) begin
			push.count = 2'd0;
		end
	end

	// scanner state and line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_q  <= LINE_ONE;
		end else if (accept) begin
			state_q <= state_n;
			line_q  <= line_n;
		end
	end

endmodule
`default_nettype wire

// ----- src/cts_res_fifo.sv -----
`default_nettype none
module cts_res_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cts_pkg::push_t  push,
	output logic                 room,
	output logic                 valid,
	input  wire logic            ready,
	output cts_pkg::res_t        head
);

	localparam logic [cts_pkg::RES_PTR_W-1:0] PTR_ONE = cts_pkg::RES_PTR_W'(1);
	localparam logic [cts_pkg::RES_CNT_W-1:0] ROOM_MAX = cts_pkg::RES_CNT_W'(cts_pkg::RES_DEPTH - 2);

	cts_pkg::res_t                   mem_q [cts_pkg::RES_DEPTH];
	logic [cts_pkg::RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [cts_pkg::RES_CNT_W-1:0]   count_q;
	logic                            pop;

	// new byte only when a two-result request still fits
	assign room  = count_q <= ROOM_MAX;
	assign valid = count_q != '0;
	assign head  = mem_q[rd_ptr_q];
	assign pop   = valid && ready;

	// result storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PTR_ONE] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cts_pkg::RES_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + cts_pkg::RES_PTR_W'(pop);
			count_q  <= count_q + cts_pkg::RES_CNT_W'(push.count) - cts_pkg::RES_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ----- src/c_like_token_scanner_top.sv -----
`default_nettype none
// Token scanner for a small C-like language. One source byte is taken per request on chars
// (byte 0 marks end of input) and its results leave on results: lexeme characters, a
// token-complete item with the token type, or an error item with its code; the last result
// of each byte has last_of_run set. A byte is accepted every cycle while the four-entry
// result queue has two free entries, so up to one byte per cycle is taken; a byte
// that gives two results (a token closed by lookahead plus the start of the next) fills two
// queue entries, and the output side sets the pace when it stalls. The scanner automaton
// and line counter update in the accepting cycle; its results are written into the queue.
module c_like_token_scanner_top (
	input wire logic  clk,
	input wire logic  arst_n,
	cts_in_if.sink    chars,
	cts_out_if.source results
);

	cts_pkg::push_t push;
	cts_pkg::res_t  head;
	logic           room;
	logic           accept;

	assign chars.ready = room;
	assign accept      = chars.valid && room;

	// automaton and line counter
	cts_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (chars.char_code),
		.push      (push)
	);

	// result queue
	cts_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (results.valid),
		.ready  (results.ready),
		.head   (head)
	);

	assign results.result_kind = head.kind;
	assign results.token_type  = head.token_type;
	assign results.char_value  = head.char_value;
	assign results.error_code  = head.error_code;
	assign results.line_number = head.line_number;
	assign results.last_of_run = head.last_of_run;

endmodule
`default_nettype wire

// ----- src/cts_checker.sv -----
`default_nettype none
module cts_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [1:0]                    out_kind,
	input wire logic [4:0]                    out_type,
	input wire logic [3:0]                    out_err,
	input wire logic [cts_pkg::LINE_BITS-1:0] out_line,
	input wire logic                          out_last
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_line))
		else $error("result changed while stalled");

	// line counter never reads zero
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_line != '0)
		else $error("line number zero");

	// an error always ends the byte's results
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == cts_pkg::KIND_ERR |-> out_last)
		else $error("error not last of run");

	// lexeme characters carry no token type or error code
	a_lex_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == cts_pkg::KIND_LEX |->
		out_type == cts_pkg::TOK_NONE && out_err == cts_pkg::ERR_NONE)
		else $error("lexeme result with stray fields");

	// end token always closes the run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == cts_pkg::KIND_TOK && out_type == cts_pkg::TOK_END |-> out_last)
		else $error("end token not last of run");

endmodule

bind c_like_token_scanner_top cts_checker u_cts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_kind  (results.result_kind),
	.out_type  (results.token_type),
	.out_err   (results.error_code),
	.out_line  (results.line_number),
	.out_last  (results.last_of_run)
);
`default_nettype wire

// ----- sim/c_like_token_scanner_top_tb.sv -----
`default_nettype none
module c_like_token_scanner_top_tb;

	// scanner states, kept by the scoreboard
	typedef enum logic [4:0] {
		ST_IDLE, ST_ID, ST_INT, ST_CH_OPEN, ST_CH_ESC, ST_CH_CLOSE, ST_STR, ST_SLASH,
		ST_LCOM, ST_BCOM, ST_BSTAR, ST_EQ, ST_BANG, ST_LT, ST_GT, ST_AMP, ST_BAR
	} scan_st_e;

	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_BSLASH = 8'd92;

	localparam int HOLD_CYCLES = 80;

	// Tracks the scanner automaton and line counter; holds results still due.
	class scan_scoreboard;
		scan_st_e                      st;
		logic [cts_pkg::LINE_BITS-1:0] line_cnt;
		cts_pkg::res_t                 due_results[$];
		int                            fails;

		function void clear();
			st = ST_IDLE;
			line_cnt = cts_pkg::LINE_BITS'(1);
			due_results.delete();
			fails = 0;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == " " || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function bit is_print(logic [7:0] c);
			return c >= 8'd32 && c <= 8'd126;
		endfunction

		function void emit(logic [1:0] kind, logic [4:0] tt, logic [7:0] ch, logic [3:0] ec);
			cts_pkg::res_t r;
			r.kind        = kind;
			r.token_type  = tt;
			r.char_value  = ch;
			r.error_code  = ec;
			r.line_number = line_cnt;
			r.last_of_run = 1'b0;
			due_results.push_back(r);
		endfunction

		function void tok(logic [4:0] tt);
			emit(cts_pkg::KIND_TOK, tt, 8'd0, cts_pkg::ERR_NONE);
		endfunction

		function void lexc(logic [7:0] c);
			emit(cts_pkg::KIND_LEX, cts_pkg::TOK_NONE, c, cts_pkg::ERR_NONE);
		endfunction

		// error drops the byte and returns to idle
		function void flag_err(logic [3:0] ec);
			emit(cts_pkg::KIND_ERR, cts_pkg::TOK_NONE, 8'd0, ec);
			st = ST_IDLE;
		endfunction

		function void bump_line();
			if (line_cnt != {cts_pkg::LINE_BITS{1'b1}})
				line_cnt = line_cnt + 1'b1;
		endfunction

		function void from_idle(logic [7:0] c);
			st = ST_IDLE;
			if (is_blank(c)) begin
				if (c == CH_NL)
					bump_line();
			end else if (is_letter(c)) begin
				lexc(c);
				st = ST_ID;
			end else if (is_digit(c)) begin
				lexc(c);
				st = ST_INT;
			end else begin
				case (c)
					CH_SQUOTE: st = ST_CH_OPEN;
					CH_DQUOTE: st = ST_STR;
					"+": tok(cts_pkg::TOK_PLUS);
					"-": tok(cts_pkg::TOK_MINUS);
					"*": tok(cts_pkg::TOK_STAR);
					"/": st = ST_SLASH;
					"=": st = ST_EQ;
					"&": st = ST_AMP;
					"|": st = ST_BAR;
					"!": st = ST_BANG;
					"<": st = ST_LT;
					">": st = ST_GT;
					"(": tok(cts_pkg::TOK_LPAREN);
					")": tok(cts_pkg::TOK_RPAREN);
					"[": tok(cts_pkg::TOK_LBRACK);
					"]": tok(cts_pkg::TOK_RBRACK);
					"{": tok(cts_pkg::TOK_LBRACE);
					"}": tok(cts_pkg::TOK_RBRACE);
					",": tok(cts_pkg::TOK_COMMA);
					";": tok(cts_pkg::TOK_SEMI);
					CH_NUL: begin
						// end of input steps the line back, floor at one
						if (line_cnt > 1)
							line_cnt = line_cnt - 1'b1;
						tok(cts_pkg::TOK_END);
					end
					default: flag_err(cts_pkg::ERR_BAD_CHAR);
				endcase
			end
		endfunction

		function void pair_or_single(logic [7:0] c, logic [4:0] pair_tok, logic [4:0] one_tok);
			if (c == "=") begin
				tok(pair_tok);
				st = ST_IDLE;
			end else begin
				tok(one_tok);
				from_idle(c);
			end
		endfunction

		function void block_body(logic [7:0] c);
			if (c == CH_NUL)
				flag_err(cts_pkg::ERR_COM_OPEN);
			else if (c == "*")
				st = ST_BSTAR;
			else begin
				if (c == CH_NL)
					bump_line();
				st = ST_BCOM;
			end
		endfunction

		// accepted byte: advance the automaton and queue its results
		function void note_byte(logic [7:0] c);
			int            n0;
			cts_pkg::res_t r;
			n0 = due_results.size();
			case (st)
				ST_ID:
					if (is_letter(c) || is_digit(c) || c == "_")
						lexc(c);
					else begin
						tok(cts_pkg::TOK_ID);
						from_idle(c);
					end
				ST_INT:
					if (is_digit(c))
						lexc(c);
					else if (is_letter(c))
						flag_err(cts_pkg::ERR_INT_ALPHA);
					else begin
						tok(cts_pkg::TOK_INT);
						from_idle(c);
					end
				ST_CH_OPEN:
					if (c == CH_BSLASH)
						st = ST_CH_ESC;
					else if (c == CH_SQUOTE)
						flag_err(cts_pkg::ERR_CHC_FORMAT);
					else if (is_print(c)) begin
						lexc(c);
						st = ST_CH_CLOSE;
					end else
						flag_err(cts_pkg::ERR_CHC_UNPRT);
				ST_CH_ESC:
					if (c == "n") begin
						lexc(CH_NL);
						st = ST_CH_CLOSE;
					end else if (c == "0") begin
						lexc(CH_NUL);
						st = ST_CH_CLOSE;
					end else
						flag_err(cts_pkg::ERR_CHC_FORMAT);
				ST_CH_CLOSE:
					if (c == CH_SQUOTE) begin
						tok(cts_pkg::TOK_CHAR);
						st = ST_IDLE;
					end else
						flag_err(cts_pkg::ERR_CHC_FORMAT);
				ST_STR:
					if (c == CH_DQUOTE) begin
						tok(cts_pkg::TOK_STR);
						st = ST_IDLE;
					end else if (c == CH_NUL)
						flag_err(cts_pkg::ERR_STR_OPEN);
					else if (is_print(c))
						lexc(c);
					else
						flag_err(cts_pkg::ERR_STR_UNPRT);
				ST_SLASH:
					if (c == "/")
						st = ST_LCOM;
					else if (c == "*")
						st = ST_BCOM;
					else begin
						tok(cts_pkg::TOK_SLASH);
						from_idle(c);
					end
				ST_LCOM:
					if (c == CH_NL) begin
						bump_line();
						st = ST_IDLE;
					end else if (c == CH_NUL)
						from_idle(c);
				ST_BCOM: block_body(c);
				ST_BSTAR:
					if (c == "/")
						st = ST_IDLE;
					else
						block_body(c);
				ST_EQ: pair_or_single(c, cts_pkg::TOK_EQ, cts_pkg::TOK_ASSIGN);
				ST_BANG: pair_or_single(c, cts_pkg::TOK_NE, cts_pkg::TOK_NOT);
				ST_LT: pair_or_single(c, cts_pkg::TOK_LE, cts_pkg::TOK_LT);
				ST_GT: pair_or_single(c, cts_pkg::TOK_GE, cts_pkg::TOK_GT);
				ST_AMP:
					if (c == "&") begin
						tok(cts_pkg::TOK_LAND);
						st = ST_IDLE;
					end else
						flag_err(cts_pkg::ERR_LONE_AMP);
				ST_BAR:
					if (c == "|") begin
						tok(cts_pkg::TOK_LOR);
						st = ST_IDLE;
					end else
						flag_err(cts_pkg::ERR_LONE_BAR);
				default: from_idle(c);
			endcase
			// mark the final result of this byte
			if (due_results.size() > n0) begin
				r = due_results.pop_back();
				r.last_of_run = 1'b1;
				due_results.push_back(r);
			end
		endfunction

		function void cmp(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(cts_pkg::res_t got);
			cts_pkg::res_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0d type %0d char %0d err %0d line %0d",
					got.kind, got.token_type, got.char_value, got.error_code, got.line_number);
				fails++;
				return;
			end
			want = due_results.pop_front();
			cmp("result_kind", 16'(want.kind), 16'(got.kind));
			cmp("token_type", 16'(want.token_type), 16'(got.token_type));
			cmp("char_value", 16'(want.char_value), 16'(got.char_value));
			cmp("error_code", 16'(want.error_code), 16'(got.error_code));
			cmp("line_number", 16'(want.line_number), 16'(got.line_number));
			cmp("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cts_in_if  chars_if();
	cts_out_if results_if();

	c_like_token_scanner_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.results(results_if)
	);

	scan_scoreboard sb;
	logic [7:0]     src_q[$];
	int             n_sent;
	int             burst_left;
	bit             steady;
	bit             hold_req;

	string op_text[22] = '{"+", "-", "*", "/", "=", "==", "!=", "<", "<=", ">", ">=",
		"&&", "||", "!", "(", ")", "[", "]", "{", "}", ",", ";"};

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			src_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_print();
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 5))
			0: return CH_NL;
			1: return 8'd9;
			2: return 8'd11;
			3: return 8'd12;
			4: return 8'd13;
			default: return " ";
		endcase
	endfunction

	// one lexeme with random content; mostly well formed, some noise and broken ones
	function automatic void add_word();
		int         n;
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				src_q.push_back(rand_letter());
				n = $urandom_range(0, 6);
				repeat (n)
					case ($urandom_range(0, 2))
						0: src_q.push_back(rand_letter());
						1: src_q.push_back(rand_digit());
						default: src_q.push_back("_");
					endcase
			end
			3, 4: begin
				n = $urandom_range(1, 5);
				repeat (n)
					src_q.push_back(rand_digit());
			end
			5: begin
				src_q.push_back(CH_SQUOTE);
				if ($urandom_range(0, 2) == 0) begin
					src_q.push_back(CH_BSLASH);
					src_q.push_back(($urandom_range(0, 1) != 0) ? "n" : "0");
				end else begin
					do c = rand_print(); while (c == CH_SQUOTE || c == CH_BSLASH);
					src_q.push_back(c);
				end
				src_q.push_back(CH_SQUOTE);
			end
			6: begin
				src_q.push_back(CH_DQUOTE);
				n = $urandom_range(0, 8);
				repeat (n) begin
					do c = rand_print(); while (c == CH_DQUOTE);
					src_q.push_back(c);
				end
				src_q.push_back(CH_DQUOTE);
			end
			7, 8, 9, 10: push_str(op_text[$urandom_range(0, 21)]);
			11: begin
				push_str("//");
				n = $urandom_range(0, 8);
				repeat (n) begin
					do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
					src_q.push_back(c);
				end
				src_q.push_back(($urandom_range(0, 7) != 0) ? CH_NL : CH_NUL);
			end
			12: begin
				push_str("/*");
				n = $urandom_range(0, 8);
				repeat (n)
					case ($urandom_range(0, 3))
						0: src_q.push_back("*");
						1: src_q.push_back(CH_NL);
						default: src_q.push_back(8'($urandom_range(1, 255)));
					endcase
				src_q.push_back("*");
				if ($urandom_range(0, 1) != 0)
					src_q.push_back("*");
				src_q.push_back("/");
			end
			13, 14, 15: src_q.push_back(rand_blank());
			16: src_q.push_back(CH_NUL);
			17: src_q.push_back(8'($urandom_range(0, 255)));
			default: begin
				// broken constructs: opener followed by a random byte
				case ($urandom_range(0, 7))
					0: src_q.push_back(CH_SQUOTE);
					1: begin
						src_q.push_back(CH_SQUOTE);
						src_q.push_back(CH_BSLASH);
					end
					2: begin
						src_q.push_back(CH_SQUOTE);
						src_q.push_back(rand_print());
					end
					3: begin
						src_q.push_back(CH_DQUOTE);
						src_q.push_back(rand_print());
						src_q.push_back(($urandom_range(0, 1) != 0) ?
							8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255)));
					end
					4: src_q.push_back("&");
					5: src_q.push_back("|");
					6: begin
						push_str("/*");
						src_q.push_back(rand_print());
						src_q.push_back(CH_NUL);
					end
					default: src_q.push_back(rand_digit());
				endcase
				src_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		if ($urandom_range(0, 1) != 0)
			src_q.push_back(" ");
	endfunction

	// one request on chars; starts and ends at a falling edge
	task automatic send_byte(input logic [7:0] c);
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (chars_if.ready !== 1'b1)
			@(posedge clk);
		sb.note_byte(c);
		n_sent++;
		@(negedge clk);
	endtask

	// drain the source queue in bursts with random gaps
	task automatic send_queue();
		int gap;
		while (src_q.size() > 0) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 2) == 0 || steady) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					chars_if.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			send_byte(src_q.pop_front());
			burst_left--;
		end
	endtask

	task automatic send_random(input int count);
		int stop_at;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			add_word();
			send_queue();
		end
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// result receiver: stalls on a changing pattern, long hold-off on request
	initial begin : receiver
		int ready_mode;
		int ready_left;
		int tick;
		ready_left = 0;
		tick = 0;
		ready_mode = 0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (ready_left == 0) begin
					ready_mode = $urandom_range(0, 3);
					ready_left = $urandom_range(10, 60);
				end
				case (ready_mode)
					0: results_if.ready <= 1'b1;
					1: results_if.ready <= 1'($urandom_range(0, 1));
					2: results_if.ready <= ($urandom_range(0, 3) == 0);
					default: results_if.ready <= ((tick % 5) != 0);
				endcase
				ready_left--;
				tick++;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : monitor
		cts_pkg::res_t got;
		if (arst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			got.kind        = results_if.result_kind;
			got.token_type  = results_if.token_type;
			got.char_value  = results_if.char_value;
			got.error_code  = results_if.error_code;
			got.line_number = results_if.line_number;
			got.last_of_run = results_if.last_of_run;
			sb.check_result(got);
		end
	end

	// run limit
	initial begin
		#6000000;
		$display("FAILED: results differ");
		$finish;
	end

	// main sequence
	initial begin
		sb = new();
		sb.clear();
		n_sent = 0;
		burst_left = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_code = 8'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, escapes, stars before slash, dropped newline and zero
		push_str("a_Z9==");
		push_str("'\\n'");
		push_str("'\\0'");
		src_q.push_back(CH_DQUOTE);
		push_str("~ ");
		src_q.push_back(CH_DQUOTE);
		push_str("<=/***/9z&");
		src_q.push_back(CH_NL);
		src_q.push_back("|");
		src_q.push_back(CH_NUL);
		src_q.push_back(CH_NUL);
		src_q.push_back(8'h80);
		src_q.push_back(8'hFF);
		push_str("//");
		src_q.push_back(CH_NUL);
		send_queue();

		send_random(170);

		// receiver holds off while the sender keeps offering
		hold_req = 1'b1;
		steady = 1'b1;
		send_random(30);
		steady = 1'b0;

		wait_drained();
		send_random(170);

		wait_drained();
		send_random(40);

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.due_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
